[hdl/otgs_pkg.sv]
// Package for the OLED text glyph streamer: geometry, codes, sequence steps and font table.
`timescale 1ns / 1ps
package otgs_pkg;

    localparam int COLUMNS     = 128;
    localparam int PAGES       = 8;
    localparam int GLYPH_WIDTH = 5;
    localparam int PAGE_W      = $clog2(PAGES);

    localparam logic OP_PRINT  = 1'b0;
    localparam logic OP_CURSOR = 1'b1;

    localparam logic [7:0] CMD_COLUMN_RANGE = 8'h21;
    localparam logic [7:0] CMD_PAGE_RANGE   = 8'h22;
    localparam logic [7:0] CODE_FIRST       = 8'h20;
    localparam logic [7:0] CODE_LAST        = 8'h7E;
    localparam logic [7:0] CODE_NEWLINE     = 8'h0A;
    localparam logic [7:0] BLANK_BYTE       = 8'h00;

    // output sequence steps: six cursor commands, five glyph columns, one spacer
    localparam logic [3:0] STEP_COL_CMD    = 4'd0;
    localparam logic [3:0] STEP_COL_START  = 4'd1;
    localparam logic [3:0] STEP_COL_END    = 4'd2;
    localparam logic [3:0] STEP_PAGE_CMD   = 4'd3;
    localparam logic [3:0] STEP_PAGE_START = 4'd4;
    localparam logic [3:0] STEP_PAGE_END   = 4'd5;
    localparam logic [3:0] STEP_GLYPH0     = 4'd6;
    localparam logic [3:0] STEP_GLYPH1     = 4'd7;
    localparam logic [3:0] STEP_GLYPH2     = 4'd8;
    localparam logic [3:0] STEP_GLYPH3     = 4'd9;
    localparam logic [3:0] STEP_GLYPH4     = 4'd10;
    localparam logic [3:0] STEP_SPACER     = 4'd11;

    localparam int FONT_DEPTH = 95;

    typedef logic [39:0] font_row_t;

    // one row per code 0x20..0x7E, leftmost column in the top byte
    localparam font_row_t FONT_ROM [FONT_DEPTH] = '{
        40'h0000000000, 40'h00002f0000, 40'h0007000700,
        40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
        40'h3649552250, 40'h0005030000, 40'h001c224100,
        40'h0041221c00, 40'h14083E0814, 40'h08083E0808,
        40'h0000A06000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
        40'h4261514946, 40'h2141454B31, 40'h1814127F10,
        40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000,
        40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324959513E,
        40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
        40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
        40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
        40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
        40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
        40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h55AA55AA55, 40'h0041417F00, 40'h0402010204,
        40'h4040404040, 40'h0003050000, 40'h2054545478,
        40'h7F48444438, 40'h3844444420, 40'h384444487F,
        40'h3854545418, 40'h087E090102, 40'h18A4A4A47C,
        40'h7F08040478, 40'h00447D4000, 40'h4080847D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
        40'h7C08040478, 40'h3844444438, 40'hFC24242418,
        40'h18242418FC, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
        40'h3C4030403C, 40'h4428102844, 40'h1CA0A0A07C,
        40'h4464544C44, 40'h00107C8200, 40'h0000FF0000,
        40'h00827C1000, 40'h0006090906
    };

endpackage

[hdl/oled_text_glyph_streamer.sv]
// Top level of the OLED text glyph streamer: cursor state, font ROM and byte sequencer.
`timescale 1ns / 1ps
//
// Turns print and set-cursor items into byte writes for a page-organized OLED.
// Input channel (in_valid/in_ready): opcode, char_code, target_page, target_column.
// Output channel (out_valid/out_ready): is_command, out_byte, last, one byte per
// transaction; last marks the final byte caused by an input item.
// A printable item gives six data bytes (glyph columns plus spacer), preceded by
// six cursor commands when it starts a new page; a newline or a valid set-cursor
// gives the six commands alone; an out-of-range set-cursor gives nothing.
// The item plan is registered at acceptance; its first byte is then loaded
// into the output register. Throughput: one byte per cycle while the receiver
// is ready; the next item is accepted in the cycle its last byte is loaded
// into the output register, so items run back to back.
// The glyph row is read from a registered font ROM at acceptance.
// Reset clears the cursor to page 0, column 0 and empties the output register.
// When the receiver stalls, the output register holds and the sequencer waits;
// input is refused until the current item's last byte has been loaded.
//
module oled_text_glyph_streamer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [7:0] char_code,
    input  logic [7:0] target_page,
    input  logic [7:0] target_column,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_command,
    output logic [7:0] out_byte,
    output logic       last
);
    import otgs_pkg::*;

    logic [PAGE_W-1:0] page_reg, page_next;
    logic [7:0]        col_reg, col_next;

    logic              busy_reg, busy_next;
    logic [3:0]        step_reg, step_next;
    logic [3:0]        end_reg, end_next;
    logic [7:0]        cmd_col_reg, cmd_col_next;
    logic [PAGE_W-1:0] cmd_page_reg, cmd_page_next;
    font_row_t         row_reg;

    logic              out_valid_reg;
    logic              is_cmd_reg;
    logic [7:0]        byte_reg;
    logic              last_reg;

    logic              advance;
    logic              at_end;
    logic              accept;
    logic              known;
    logic [6:0]        font_idx;
    logic              wrap;
    logic              cursor_ok;
    logic [PAGE_W-1:0] page_inc;
    logic [7:0]        byte_sel;

    assign advance  = busy_reg && (!out_valid_reg || out_ready);
    assign at_end   = (step_reg == end_reg);
    assign in_ready = !busy_reg || (advance && at_end);
    assign accept   = in_valid && in_ready;

    assign known    = (char_code >= CODE_FIRST) && (char_code <= CODE_LAST);
    assign font_idx = 7'(char_code - CODE_FIRST);
    assign page_inc = (page_reg == PAGE_W'(PAGES - 1)) ? '0 : PAGE_W'(page_reg + 1'b1);
    assign wrap     = (char_code == CODE_NEWLINE)
                   || ({1'b0, col_reg} + 9'(GLYPH_WIDTH) >= 9'(COLUMNS));
    assign cursor_ok = (target_page < 8'(PAGES)) && ({1'b0, target_column} < 9'(COLUMNS));

    // sequencer stepping, and cursor update and item plan taken at acceptance
    always_comb
    begin
        page_next     = page_reg;
        col_next      = col_reg;
        busy_next     = busy_reg;
        step_next     = step_reg;
        end_next      = end_reg;
        cmd_col_next  = cmd_col_reg;
        cmd_page_next = cmd_page_reg;
        if (advance)
        begin
            if (at_end)
                busy_next = 1'b0;
            else
                step_next = step_reg + 4'd1;
        end
        if (accept)
        begin
            if (opcode == OP_CURSOR)
            begin
                if (cursor_ok)
                begin
                    page_next     = target_page[PAGE_W-1:0];
                    col_next      = target_column;
                    cmd_page_next = target_page[PAGE_W-1:0];
                    cmd_col_next  = target_column;
                    busy_next     = 1'b1;
                    step_next     = STEP_COL_CMD;
                    end_next      = STEP_PAGE_END;
                end
            end
            else
            begin
                busy_next     = 1'b1;
                cmd_page_next = page_inc;
                cmd_col_next  = '0;
                step_next     = wrap ? STEP_COL_CMD : STEP_GLYPH0;
                end_next      = STEP_SPACER;
                if (char_code == CODE_NEWLINE)
                begin
                    end_next = STEP_PAGE_END;
                    page_next = page_inc;
                    col_next  = '0;
                end
                else if (wrap)
                begin
                    page_next = page_inc;
                    col_next  = 8'(GLYPH_WIDTH + 1);
                end
                else
                begin
                    col_next = 8'(col_reg + 8'(GLYPH_WIDTH + 1));
                end
            end
        end
    end

    always_comb
    begin
        case (step_reg)
            STEP_COL_CMD:    byte_sel = CMD_COLUMN_RANGE;
            STEP_COL_START:  byte_sel = cmd_col_reg;
            STEP_COL_END:    byte_sel = 8'(COLUMNS - 1);
            STEP_PAGE_CMD:   byte_sel = CMD_PAGE_RANGE;
            STEP_PAGE_START: byte_sel = 8'(cmd_page_reg);
            STEP_PAGE_END:   byte_sel = 8'(PAGES - 1);
            STEP_GLYPH0:     byte_sel = row_reg[39:32];
            STEP_GLYPH1:     byte_sel = row_reg[31:24];
            STEP_GLYPH2:     byte_sel = row_reg[23:16];
            STEP_GLYPH3:     byte_sel = row_reg[15:8];
            STEP_GLYPH4:     byte_sel = row_reg[7:0];
            default:         byte_sel = BLANK_BYTE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg      <= '0;
            col_reg       <= '0;
            busy_reg      <= 1'b0;
            step_reg      <= STEP_COL_CMD;
            end_reg       <= STEP_PAGE_END;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            page_reg <= page_next;
            col_reg  <= col_next;
            busy_reg <= busy_next;
            step_reg <= step_next;
            end_reg  <= end_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_col_reg  <= cmd_col_next;
        cmd_page_reg <= cmd_page_next;
        // font ROM, registered read; the row register is only read by glyph steps
        if (accept)
            row_reg <= known ? FONT_ROM[font_idx] : '0;
        if (advance)
        begin
            is_cmd_reg <= (step_reg < STEP_GLYPH0);
            byte_reg   <= byte_sel;
            last_reg   <= at_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_command = is_cmd_reg;
    assign out_byte   = byte_reg;
    assign last       = last_reg;

endmodule
